// File: hdl/gsc_pkg.sv
`default_nettype none

package gsc_pkg;

	// window and field sizes
	localparam int WINDOW_LENGTH = 8;
	localparam int POS_W         = $clog2(WINDOW_LENGTH + 1);
	localparam int DIST_W        = 12;
	localparam int HCNT_W        = 7;
	localparam int SUM_W         = 20;
	localparam int VCNT_W        = 8;
	localparam int LMAJ_W        = 7;
	localparam int DMAJ_W        = 8;
	localparam int PROD_W        = SUM_W + VCNT_W;
	localparam int QUO_W         = DIST_W;
	localparam int DSTEP_W       = $clog2(QUO_W);
	localparam int GEST_W        = 3;

	// configuration port
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int RIDX_W = 3;

	localparam logic [RIDX_W-1:0] REG_MIN_HIGH  = 3'd0;
	localparam logic [RIDX_W-1:0] REG_MAX_HIGH  = 3'd1;
	localparam logic [RIDX_W-1:0] REG_LEVEL_MAJ = 3'd2;
	localparam logic [RIDX_W-1:0] REG_DIST_MAJ  = 3'd3;
	localparam logic [RIDX_W-1:0] REG_DELTA     = 3'd4;

	// gesture codes
	localparam logic [GEST_W-1:0] GEST_NONE        = 3'd0;
	localparam logic [GEST_W-1:0] GEST_PULL        = 3'd1;
	localparam logic [GEST_W-1:0] GEST_PUSH        = 3'd2;
	localparam logic [GEST_W-1:0] GEST_SWIPE_LEFT  = 3'd3;
	localparam logic [GEST_W-1:0] GEST_SWIPE_RIGHT = 3'd4;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LEFT,
		ST_RIGHT,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

// File: hdl/two_sensor_gesture_classifier.sv
// An item is taken in ST_IDLE; its left and right readings accumulate in ST_LEFT, ST_RIGHT.
// The item that closes a window adds 4 multiply steps, a compare state, 12 divide steps
// (only when the mean is valid) and ST_DONE, which loads the output register once it is free.
// Items are taken only in ST_IDLE: no new item is taken before the last one is through.
// A shared adder, one shared multiplier and a one-bit-per-cycle divider serve these steps.
// arst_n clears the sequencer, window counters, history, configuration registers and out_valid.
`default_nettype none

module two_sensor_gesture_classifier (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input channel
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [gsc_pkg::DIST_W-1:0]          left_distance,
	input  wire logic [gsc_pkg::DIST_W-1:0]          right_distance,
	// output channel
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [gsc_pkg::GEST_W-1:0]               gesture,
	output logic [gsc_pkg::DIST_W-1:0]               mean_distance,
	output logic                                     mean_valid,
	output logic                                     left_level,
	output logic                                     right_level,
	// configuration port
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [gsc_pkg::ADDR_W-1:0]          paddr,
	input  wire logic [gsc_pkg::DATA_W-1:0]          pwdata,
	output logic [gsc_pkg::DATA_W-1:0]               prdata,
	output logic                                     pready
);

	gsc_pkg::state_t state_q, state_nxt;

	// configuration registers
	logic [gsc_pkg::DIST_W-1:0] min_high_q;
	logic [gsc_pkg::DIST_W-1:0] max_high_q;
	logic [gsc_pkg::LMAJ_W-1:0] level_maj_q;
	logic [gsc_pkg::DMAJ_W-1:0] dist_maj_q;
	logic [gsc_pkg::DIST_W-1:0] delta_q;

	// latched input word
	logic [gsc_pkg::DIST_W-1:0] left_q, right_q;

	// window state
	logic [gsc_pkg::POS_W-1:0]  pos_q;
	logic [gsc_pkg::HCNT_W-1:0] left_cnt_q, right_cnt_q;
	logic [gsc_pkg::SUM_W-1:0]  sum_q;
	logic [gsc_pkg::VCNT_W-1:0] vcnt_q;

	// previous window
	logic [gsc_pkg::SUM_W-1:0]  prior_sum_q;
	logic [gsc_pkg::VCNT_W-1:0] prior_vcnt_q;
	logic                       prior_mean_valid_q;
	logic [1:0]                 prior_levels_q;
	logic                       prior_levels_valid_q;

	// multiply and divide working registers
	logic [1:0]                  mstep_q;
	logic [gsc_pkg::PROD_W-1:0]  cur_q, pre_q, lim_q;
	logic [gsc_pkg::SUM_W-1:0]   tmp_q;
	logic [gsc_pkg::SUM_W-1:0]   rem_q;
	logic [gsc_pkg::QUO_W-1:0]   quo_q;
	logic [gsc_pkg::DSTEP_W-1:0] dstep_q;

	// classified window waiting for the output register
	logic [gsc_pkg::GEST_W-1:0] gest_q;
	logic                       valid_q;
	logic                       lvl_l_q, lvl_r_q;

	// output register
	logic                       out_valid_q;
	logic [gsc_pkg::GEST_W-1:0] out_gest_q;
	logic [gsc_pkg::DIST_W-1:0] out_mean_q;
	logic                       out_mvalid_q;
	logic                       out_lvl_l_q, out_lvl_r_q;

	logic in_acc, out_acc, out_load, cfg_wr;
	logic [gsc_pkg::RIDX_W-1:0] cfg_idx;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid_q && out_ready;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[gsc_pkg::ADDR_W-1:2];
	assign pready  = 1'b1;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_high_q  <= '0;
			max_high_q  <= '1;
			level_maj_q <= gsc_pkg::LMAJ_W'(4);
			dist_maj_q  <= gsc_pkg::DMAJ_W'(8);
			delta_q     <= gsc_pkg::DIST_W'(5);
		end else if (cfg_wr) begin
			case (cfg_idx)
				gsc_pkg::REG_MIN_HIGH:  min_high_q  <= pwdata[gsc_pkg::DIST_W-1:0];
				gsc_pkg::REG_MAX_HIGH:  max_high_q  <= pwdata[gsc_pkg::DIST_W-1:0];
				gsc_pkg::REG_LEVEL_MAJ: level_maj_q <= pwdata[gsc_pkg::LMAJ_W-1:0];
				gsc_pkg::REG_DIST_MAJ:  dist_maj_q  <= pwdata[gsc_pkg::DMAJ_W-1:0];
				gsc_pkg::REG_DELTA:     delta_q     <= pwdata[gsc_pkg::DIST_W-1:0];
				default: ;
			endcase
		end
	end

	// configuration read
	always_comb begin
		case (cfg_idx)
			gsc_pkg::REG_MIN_HIGH:  prdata = gsc_pkg::DATA_W'(min_high_q);
			gsc_pkg::REG_MAX_HIGH:  prdata = gsc_pkg::DATA_W'(max_high_q);
			gsc_pkg::REG_LEVEL_MAJ: prdata = gsc_pkg::DATA_W'(level_maj_q);
			gsc_pkg::REG_DIST_MAJ:  prdata = gsc_pkg::DATA_W'(dist_maj_q);
			gsc_pkg::REG_DELTA:     prdata = gsc_pkg::DATA_W'(delta_q);
			default:                prdata = '0;
		endcase
	end

	// shared accumulate adder: left reading in ST_LEFT, right reading in ST_RIGHT
	logic [gsc_pkg::DIST_W-1:0] acc_dist;
	logic                       acc_hit;
	logic [gsc_pkg::SUM_W-1:0]  acc_sum;

	assign acc_dist = (state_q == gsc_pkg::ST_LEFT) ? left_q : right_q;
	assign acc_hit  = (acc_dist >= min_high_q) && (acc_dist <= max_high_q);
	assign acc_sum  = sum_q + gsc_pkg::SUM_W'(acc_dist);

	// shared multiplier, operands chosen by the step count
	logic [gsc_pkg::SUM_W-1:0]  mul_a;
	logic [gsc_pkg::VCNT_W-1:0] mul_b;
	logic [gsc_pkg::PROD_W-1:0] mul_p;

	always_comb begin
		case (mstep_q)
			2'd0:    begin mul_a = sum_q;                      mul_b = prior_vcnt_q; end
			2'd1:    begin mul_a = prior_sum_q;                mul_b = vcnt_q;       end
			2'd2:    begin mul_a = gsc_pkg::SUM_W'(delta_q);   mul_b = vcnt_q;       end
			default: begin mul_a = tmp_q;                      mul_b = prior_vcnt_q; end
		endcase
	end
	assign mul_p = gsc_pkg::PROD_W'(mul_a) * gsc_pkg::PROD_W'(mul_b);

	// window close: levels, mean validity and gesture
	logic                       cls_lvl_l, cls_lvl_r, cls_valid, cur_gt;
	logic [gsc_pkg::PROD_W-1:0] cls_diff;
	logic [gsc_pkg::GEST_W-1:0] cls_gest;

	always_comb begin
		cls_lvl_l = (left_cnt_q >= level_maj_q);
		cls_lvl_r = (right_cnt_q >= level_maj_q);
		cls_valid = (vcnt_q != '0) && (vcnt_q >= dist_maj_q);
		cur_gt    = (cur_q > pre_q);
		cls_diff  = cur_gt ? (cur_q - pre_q) : (pre_q - cur_q);
		cls_gest  = gsc_pkg::GEST_NONE;
		if (cls_valid && prior_mean_valid_q && (prior_vcnt_q != '0) && (cls_diff >= lim_q)) begin
			cls_gest = cur_gt ? gsc_pkg::GEST_PULL : gsc_pkg::GEST_PUSH;
		end else if (prior_levels_valid_q) begin
			if (!prior_levels_q[0] && cls_lvl_l && prior_levels_q[1] && !cls_lvl_r) begin
				cls_gest = gsc_pkg::GEST_SWIPE_LEFT;
			end else if (prior_levels_q[0] && !cls_lvl_l && !prior_levels_q[1] && cls_lvl_r) begin
				cls_gest = gsc_pkg::GEST_SWIPE_RIGHT;
			end
		end
	end

	// restoring divide step, one quotient bit per cycle
	logic [gsc_pkg::SUM_W-1:0] div_sub;
	logic                      div_ge;

	assign div_sub = gsc_pkg::SUM_W'(prior_vcnt_q) << dstep_q;
	assign div_ge  = (rem_q >= div_sub);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			gsc_pkg::ST_IDLE:  if (in_valid) state_nxt = gsc_pkg::ST_LEFT;
			gsc_pkg::ST_LEFT:  state_nxt = gsc_pkg::ST_RIGHT;
			gsc_pkg::ST_RIGHT: begin
				if (pos_q == gsc_pkg::POS_W'(gsc_pkg::WINDOW_LENGTH - 1))
					state_nxt = gsc_pkg::ST_MUL;
				else
					state_nxt = gsc_pkg::ST_IDLE;
			end
			gsc_pkg::ST_MUL:   if (mstep_q == 2'd3) state_nxt = gsc_pkg::ST_CMP;
			gsc_pkg::ST_CMP:   state_nxt = cls_valid ? gsc_pkg::ST_DIV : gsc_pkg::ST_DONE;
			gsc_pkg::ST_DIV:   if (dstep_q == '0) state_nxt = gsc_pkg::ST_DONE;
			gsc_pkg::ST_DONE:  if (!out_valid_q || out_ready) state_nxt = gsc_pkg::ST_IDLE;
			default:           state_nxt = gsc_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			gsc_pkg::ST_IDLE: in_ready = 1'b1;
			gsc_pkg::ST_DONE: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= gsc_pkg::ST_IDLE;
		else
			state_q <= state_nxt;
	end

	// input word latch
	always_ff @(posedge clk) begin
		if (in_acc) begin
			left_q  <= left_distance;
			right_q <= right_distance;
		end
	end

	// window accumulation, close and history update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q                <= '0;
			left_cnt_q           <= '0;
			right_cnt_q          <= '0;
			sum_q                <= '0;
			vcnt_q               <= '0;
			prior_sum_q          <= '0;
			prior_vcnt_q         <= '0;
			prior_mean_valid_q   <= 1'b0;
			prior_levels_q       <= '0;
			prior_levels_valid_q <= 1'b0;
			mstep_q              <= '0;
			dstep_q              <= '0;
		end else begin
			case (state_q)
				gsc_pkg::ST_LEFT: begin
					if (acc_hit) begin
						left_cnt_q <= left_cnt_q + 1'b1;
						sum_q      <= acc_sum;
						vcnt_q     <= vcnt_q + 1'b1;
					end
				end
				gsc_pkg::ST_RIGHT: begin
					if (acc_hit) begin
						right_cnt_q <= right_cnt_q + 1'b1;
						sum_q       <= acc_sum;
						vcnt_q      <= vcnt_q + 1'b1;
					end
					pos_q   <= pos_q + 1'b1;
					mstep_q <= '0;
				end
				gsc_pkg::ST_MUL: mstep_q <= mstep_q + 1'b1;
				gsc_pkg::ST_CMP: begin
					prior_sum_q          <= sum_q;
					prior_vcnt_q         <= vcnt_q;
					prior_mean_valid_q   <= cls_valid;
					prior_levels_q       <= {cls_lvl_r, cls_lvl_l};
					prior_levels_valid_q <= 1'b1;
					pos_q                <= '0;
					left_cnt_q           <= '0;
					right_cnt_q          <= '0;
					sum_q                <= '0;
					vcnt_q               <= '0;
					dstep_q              <= gsc_pkg::DSTEP_W'(gsc_pkg::QUO_W - 1);
				end
				gsc_pkg::ST_DIV: dstep_q <= dstep_q - 1'b1;
				default: ;
			endcase
		end
	end

	// multiplier products, classification and divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			gsc_pkg::ST_MUL: begin
				case (mstep_q)
					2'd0:    cur_q <= mul_p;
					2'd1:    pre_q <= mul_p;
					2'd2:    tmp_q <= mul_p[gsc_pkg::SUM_W-1:0];
					default: lim_q <= mul_p;
				endcase
			end
			gsc_pkg::ST_CMP: begin
				gest_q  <= cls_gest;
				valid_q <= cls_valid;
				lvl_l_q <= cls_lvl_l;
				lvl_r_q <= cls_lvl_r;
				rem_q   <= sum_q;
				quo_q   <= '0;
			end
			gsc_pkg::ST_DIV: begin
				if (div_ge)
					rem_q <= rem_q - div_sub;
				quo_q <= {quo_q[gsc_pkg::QUO_W-2:0], div_ge};
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_acc)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_gest_q   <= gest_q;
			out_mean_q   <= valid_q ? quo_q : '0;
			out_mvalid_q <= valid_q;
			out_lvl_l_q  <= lvl_l_q;
			out_lvl_r_q  <= lvl_r_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign gesture       = out_gest_q;
	assign mean_distance = out_mean_q;
	assign mean_valid    = out_mvalid_q;
	assign left_level    = out_lvl_l_q;
	assign right_level   = out_lvl_r_q;

`ifndef SYNTHESIS
	// busy for the accumulate steps after taking a word
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input taken while previous word still accumulating");

	// pull and push need a valid mean
	a_push_pull_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (gesture == gsc_pkg::GEST_PULL || gesture == gsc_pkg::GEST_PUSH)
		|-> mean_valid)
		else $error("push or pull reported without a valid mean");

	// invalid mean reads as zero
	a_invalid_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !mean_valid |-> mean_distance == '0)
		else $error("invalid mean not zero");

	// window position never exceeds the window length, which it reaches only while the window closes
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= gsc_pkg::POS_W'(gsc_pkg::WINDOW_LENGTH))
		else $error("window position out of range");

	// window counters are clear once a window has closed
	a_clear_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gsc_pkg::ST_CMP |=> vcnt_q == '0 && sum_q == '0)
		else $error("window not cleared at close");
`endif

endmodule

`default_nettype wire
